// ===== sv/pbsr_pkg.sv =====
// Package for the polled bus slave responder.
// Holds item and result types, action and status codes, and the call byte function.
// Depends on nothing; every other file refers to it by scoped names.
package pbsr_pkg;

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_RX_BYTE = 2'd1;
	localparam logic [1:0] ACT_TX_DONE = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	localparam logic [7:0] CALL_BASE  = 8'h40;
	localparam logic [7:0] PARITY_BIT = 8'h80;

	localparam int KQ_DEPTH = 2;

	typedef enum logic [1:0] {
		K_NOP,
		K_ENQ,
		K_CALL,
		K_TICK
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       driver_enable;
		logic [1:0] status;
		logic       queue_empty;
	} result_t;

	function automatic logic [7:0] call_byte(input logic [4:0] addr);
		logic [7:0] c;
		c = CALL_BASE + {3'b000, addr};
		if (^c[6:0]) begin
			c = c ^ PARITY_BIT;
		end
		return c;
	endfunction

endpackage

// ===== sv/polled_bus_slave_responder_top.sv =====
// Top level of the polled bus slave responder.
// Instantiates pbsr_front, pbsr_kq and pbsr_back; depends on pbsr_pkg.
//
// The block takes one item per clock cycle while the command queue has room and returns one
// result for each item: the front classifies the item and compares received bytes with the
// call byte, a two-entry command queue holds it, and the back executes it against the
// response byte memory. That memory has one write port and two read ports whose registered
// outputs always hold the two oldest bytes, which lets a call pop the length byte and the
// first data byte in the same cycle. The response memory is not cleared after reset and
// needs no clearing pass. The address register may be written only while no item is in
// flight; its channel is always ready.
module polled_bus_slave_responder_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] byte_value,
	input  logic       rx_error,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       driver_enable,
	output logic [1:0] status,
	output logic       queue_empty
);

	pbsr_pkg::item_t   f_item;
	logic              f_valid;
	logic              f_ready;
	pbsr_pkg::item_t   b_item;
	logic              b_valid;
	logic              b_ready;
	pbsr_pkg::result_t res;

	pbsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.byte_value (byte_value),
		.rx_error   (rx_error),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	pbsr_kq u_kq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	pbsr_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign tx_valid      = res.tx_valid;
	assign tx_byte       = res.tx_byte;
	assign driver_enable = res.driver_enable;
	assign status        = res.status;
	assign queue_empty   = res.queue_empty;

endmodule

// ===== sv/pbsr_front.sv =====
// Front part of the polled bus slave responder: address register and item classification.
// Depends on pbsr_pkg; feeds the command queue pbsr_kq.
module pbsr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         byte_value,
	input  logic               rx_error,
	output logic               item_valid,
	input  logic               item_ready,
	output pbsr_pkg::item_t    item
);

	logic [7:0] call_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_q <= pbsr_pkg::call_byte(5'd0);
		end else if (cfg_valid && cfg_ready) begin
			call_q <= pbsr_pkg::call_byte(cfg_data);
		end
	end

	always_comb begin
		item.data = byte_value;
		case (action)
			pbsr_pkg::ACT_ENQUEUE: item.kind = pbsr_pkg::K_ENQ;
			pbsr_pkg::ACT_RX_BYTE: begin
				if (!rx_error && byte_value == call_q) begin
					item.kind = pbsr_pkg::K_CALL;
				end else begin
					item.kind = pbsr_pkg::K_NOP;
				end
			end
			pbsr_pkg::ACT_TX_DONE: item.kind = pbsr_pkg::K_TICK;
			default: item.kind = pbsr_pkg::K_NOP;
		endcase
	end

	assign item_valid = in_valid;
	assign in_ready   = item_ready;

endmodule

// ===== sv/pbsr_kq.sv =====
// Two-entry command queue between the front and back parts of the responder.
// Depends on pbsr_pkg for the item type.
module pbsr_kq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  pbsr_pkg::item_t    wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output pbsr_pkg::item_t    rd_item
);

	pbsr_pkg::item_t entry_q [pbsr_pkg::KQ_DEPTH];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	assign wr_ready = (cnt_q != 2'(pbsr_pkg::KQ_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = entry_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/pbsr_back.sv =====
// Back part of the responder: response byte memory, transmit sequencing and result register.
// Depends on pbsr_pkg; takes classified items from pbsr_kq.
module pbsr_back #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  pbsr_pkg::item_t    item,
	output logic               res_valid,
	input  logic               res_ready,
	output pbsr_pkg::result_t  res
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]        mem [QUEUE_DEPTH];
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [7:0]        bytes_left_q;
	logic              driver_q;
	logic [7:0]        rd0_q;
	logic [7:0]        rd1_q;
	logic              res_valid_q;
	pbsr_pkg::result_t res_q;

	logic              exec;
	logic              wr_en;
	logic [1:0]        pop_n;
	logic [7:0]        bl_d;
	logic              drv_d;
	logic              tx_v;
	logic [7:0]        tx_b;
	logic [1:0]        st;
	logic [AW-1:0]     head_d;
	logic [AW-1:0]     head_d1;
	logic [CW-1:0]     count_d;

	assign item_ready = !res_valid_q || res_ready;
	assign exec       = item_valid && item_ready;

	always_comb begin
		wr_en = 1'b0;
		pop_n = 2'd0;
		bl_d  = bytes_left_q;
		drv_d = driver_q;
		tx_v  = 1'b0;
		tx_b  = 8'd0;
		st    = pbsr_pkg::STATUS_OK;
		if (exec) begin
			case (item.kind)
				pbsr_pkg::K_ENQ: begin
					if (count_q == CW'(QUEUE_DEPTH)) begin
						st = pbsr_pkg::STATUS_FULL;
					end else begin
						wr_en = 1'b1;
					end
				end
				pbsr_pkg::K_CALL: begin
					if (count_q != '0 && !driver_q) begin
						pop_n = 2'd1;
						if (rd0_q >= 8'd2) begin
							if (count_q >= CW'(2)) begin
								pop_n = 2'd2;
								bl_d  = rd0_q - 8'd2;
								tx_v  = 1'b1;
								tx_b  = rd1_q;
								drv_d = 1'b1;
							end else begin
								st    = pbsr_pkg::STATUS_UNDERFLOW;
								bl_d  = 8'd0;
								drv_d = 1'b0;
							end
						end
					end
				end
				pbsr_pkg::K_TICK: begin
					if (driver_q) begin
						if (bytes_left_q != 8'd0) begin
							if (count_q != '0) begin
								pop_n = 2'd1;
								bl_d  = bytes_left_q - 8'd1;
								tx_v  = 1'b1;
								tx_b  = rd0_q;
							end else begin
								st    = pbsr_pkg::STATUS_UNDERFLOW;
								bl_d  = 8'd0;
								drv_d = 1'b0;
							end
						end else begin
							drv_d = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pop_n)
			2'd1:    head_d = ptr_inc(head_q);
			2'd2:    head_d = ptr_inc(ptr_inc(head_q));
			default: head_d = head_q;
		endcase
		head_d1 = ptr_inc(head_d);
		count_d = count_q + CW'(wr_en) - CW'(pop_n);
	end

	// The two head entries are read ahead every cycle so that a call can pop two bytes at once.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= item.data;
		end
		rd0_q <= (wr_en && tail_q == head_d) ? item.data : mem[head_d];
		rd1_q <= (wr_en && tail_q == head_d1) ? item.data : mem[head_d1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			bytes_left_q <= 8'd0;
			driver_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			count_q <= count_d;
			if (wr_en) begin
				tail_q <= ptr_inc(tail_q);
			end
			bytes_left_q <= bl_d;
			driver_q <= drv_d;
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q.tx_valid      <= tx_v;
			res_q.tx_byte       <= tx_b;
			res_q.driver_enable <= drv_d;
			res_q.status        <= st;
			res_q.queue_empty   <= (count_d == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/pbsr_chk.sv =====
// Port checker for the polled bus slave responder, bound to the top level.
// Depends on pbsr_pkg for the status codes.
module pbsr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       driver_enable,
	input logic [1:0] status
);

	a_tx_needs_driver: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> driver_enable)
		else $error("A byte is sent while the driver is off.");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'd0)
		else $error("The transmit byte is not zero without a transfer to the bus.");

	a_underflow_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pbsr_pkg::STATUS_UNDERFLOW |-> !tx_valid && !driver_enable)
		else $error("An underflow did not stop the transmission.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == pbsr_pkg::STATUS_OK || status == pbsr_pkg::STATUS_FULL
			|| status == pbsr_pkg::STATUS_UNDERFLOW)
		else $error("The status holds an undefined code.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(status))
		else $error("A stalled result changed before its transfer.");

endmodule

bind polled_bus_slave_responder_top pbsr_chk u_pbsr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.tx_valid      (tx_valid),
	.tx_byte       (tx_byte),
	.driver_enable (driver_enable),
	.status        (status)
);
